>>> design/cibl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cibl_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_COUNT    = 3'd1,
    OP_FINALIZE = 3'd2,
    OP_WRITE    = 3'd3,
    OP_SORT     = 3'd4,
    OP_LOOKUP   = 3'd5
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_FIN_END,
    S_RNG_A,
    S_RNG_B,
    S_RNG_C,
    S_LK_RD,
    S_LK_CMP,
    S_LK_FIN,
    S_SRT_NEXT,
    S_SRT_KEY,
    S_SRT_RD,
    S_SRT_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [9:0]  index;
    logic        found;
    logic [10:0] total_nonzeros;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

>>> design/csr_index_build_and_lookup_top.sv
// Lookup runs a lower-bound binary search over the columns of the row; sort runs
// an insertion sort on each row in turn.
// One item at a time; a finished result waits in an output register.
// After reset the row offset memory is swept to zero with in_stall_o high;
// row_count resets to 1.
`timescale 1ns / 1ps
`default_nettype none

module csr_index_build_and_lookup_top import cibl_pkg::*; #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_NONZEROS = 1024,
  parameter int COLUMN_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [15:0] column_i,
  input  wire logic [9:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       index_o,
  output logic             found_o,
  output logic [10:0]      total_nonzeros_o,
  output logic [1:0]       status_o
);

  localparam int RA = $clog2(MAX_ROWS + 1);
  localparam int OW = $clog2(MAX_NONZEROS + 1);
  localparam int PW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

  logic [8:0] row_count_q;
  logic [RA-1:0] rows;
  logic res_valid, res_take;
  res_t res, out_q;
  logic out_valid_q;
  logic off_we, col_we;
  logic [RA-1:0] off_waddr, off_raddr;
  logic [OW-1:0] off_wdata, off_rdata;
  logic [PW-1:0] col_waddr, col_raddr;
  logic [COLUMN_BITS-1:0] col_wdata, col_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 9'd1;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  // Zero acts as one row; anything above the array size is clamped.
  always_comb begin
    if (row_count_q == '0) begin
      rows = RA'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows = RA'(MAX_ROWS);
    end else begin
      rows = RA'(row_count_q);
    end
  end

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign index_o          = out_q.index;
  assign found_o          = out_q.found;
  assign total_nonzeros_o = out_q.total_nonzeros;
  assign status_o         = out_q.status;

  cibl_seq #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_NONZEROS(MAX_NONZEROS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .off_we_o    (off_we),
    .off_waddr_o (off_waddr),
    .off_wdata_o (off_wdata),
    .off_raddr_o (off_raddr),
    .off_rdata_i (off_rdata),
    .col_we_o    (col_we),
    .col_waddr_o (col_waddr),
    .col_wdata_o (col_wdata),
    .col_raddr_o (col_raddr),
    .col_rdata_i (col_rdata)
  );

  cibl_ram #(
    .WIDTH(OW),
    .DEPTH(MAX_ROWS + 1)
  ) u_off_ram (
    .clk_i  (clk_i),
    .we_i   (off_we),
    .waddr_i(off_waddr),
    .wdata_i(off_wdata),
    .raddr_i(off_raddr),
    .rdata_o(off_rdata)
  );

  cibl_ram #(
    .WIDTH(COLUMN_BITS),
    .DEPTH(MAX_NONZEROS)
  ) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(col_waddr),
    .wdata_i(col_wdata),
    .raddr_i(col_raddr),
    .rdata_o(col_rdata)
  );

endmodule

`default_nettype wire

>>> design/cibl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cibl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/cibl_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module cibl_seq import cibl_pkg::*; #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_NONZEROS = 1024,
  parameter int COLUMN_BITS  = 16,
  localparam int RA = $clog2(MAX_ROWS + 1),
  localparam int OW = $clog2(MAX_NONZEROS + 1),
  localparam int PW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [RA-1:0]          rows_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [2:0]             operation_i,
  input  wire logic [7:0]             row_i,
  input  wire logic [15:0]            column_i,
  input  wire logic [9:0]             position_i,
  output logic                        res_valid_o,
  output res_t                        res_o,
  input  wire logic                   res_take_i,
  output logic                        off_we_o,
  output logic [RA-1:0]               off_waddr_o,
  output logic [OW-1:0]               off_wdata_o,
  output logic [RA-1:0]               off_raddr_o,
  input  wire logic [OW-1:0]          off_rdata_i,
  output logic                        col_we_o,
  output logic [PW-1:0]               col_waddr_o,
  output logic [COLUMN_BITS-1:0]      col_wdata_o,
  output logic [PW-1:0]               col_raddr_o,
  input  wire logic [COLUMN_BITS-1:0] col_rdata_i
);

  localparam int IW = OW + 1;
  localparam logic [OW-1:0] MAXV = OW'(MAX_NONZEROS);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   clr_op_q, clr_op_d;
  logic [RA-1:0] r_q, r_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, key_q, key_d;
  logic [OW-1:0] total_q, total_d, sum_q, sum_d;
  logic [OW-1:0] s_q, s_d, e_q, e_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [9:0] idx_q, idx_d;
  logic found_q, found_d;
  logic [1:0] status_q, status_d;
  logic row_ok, pos_ok;
  logic [OW-1:0] rd_clamp, mid_w;

  function automatic logic [OW-1:0] clampo(input logic [OW-1:0] v);
    return (v > MAXV) ? MAXV : v;
  endfunction

  assign row_ok   = 32'(row_i) < 32'(rows_i);
  assign pos_ok   = 32'(position_i) < MAX_NONZEROS;
  assign rd_clamp = clampo(off_rdata_i);
  assign mid_w    = lo_q + ((hi_q - lo_q) >> 1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o = '{index: idx_q, found: found_q, total_nonzeros: 11'(total_q),
                   status: status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_op_q <= 1'b0;
      r_q      <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_op_q <= clr_op_d;
      r_q      <= r_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    col_q    <= col_d;
    key_q    <= key_d;
    sum_q    <= sum_d;
    s_q      <= s_d;
    e_q      <= e_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    i_q      <= i_d;
    j_q      <= j_d;
    idx_q    <= idx_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    clr_op_d = clr_op_q;
    r_d      = r_q;
    col_d    = col_q;
    key_d    = key_q;
    total_d  = total_q;
    sum_d    = sum_q;
    s_d      = s_q;
    e_d      = e_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    i_d      = i_q;
    j_d      = j_q;
    idx_d    = idx_q;
    found_d  = found_q;
    status_d = status_q;
    off_we_o    = 1'b0;
    off_waddr_o = r_q;
    off_wdata_o = '0;
    off_raddr_o = r_q;
    col_we_o    = 1'b0;
    col_waddr_o = j_q[PW-1:0];
    col_wdata_o = key_q;
    col_raddr_o = i_q[PW-1:0];

    unique case (state_q)
      S_CLR: begin
        off_we_o = 1'b1;
        total_d  = '0;
        r_d      = r_q + 1'b1;
        if (r_q == RA'(MAX_ROWS)) begin
          state_d = clr_op_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          col_d    = COLUMN_BITS'(column_i);
          idx_d    = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          r_d      = '0;
          sum_d    = '0;
          state_d  = S_DONE;
          unique case (op_e'(operation_i))
            OP_CLEAR: begin
              clr_op_d = 1'b1;
              state_d  = S_CLR;
            end
            OP_COUNT: begin
              r_d = RA'(row_i);
              if (!row_ok) begin
                status_d = ST_MISS;
              end else if (total_q >= MAXV) begin
                status_d = ST_OVF;
              end else begin
                state_d = S_CNT_RD;
              end
            end
            OP_FINALIZE: state_d = S_FIN_RD;
            OP_WRITE: begin
              col_we_o    = pos_ok;
              col_waddr_o = PW'(position_i);
              col_wdata_o = COLUMN_BITS'(column_i);
            end
            OP_SORT: state_d = S_RNG_A;
            OP_LOOKUP: begin
              r_d = RA'(row_i);
              if (!row_ok) begin
                status_d = ST_MISS;
              end else begin
                state_d = S_RNG_A;
              end
            end
            default: ;
          endcase
        end
      end
      S_CNT_RD: state_d = S_CNT_WR;
      S_CNT_WR: begin
        off_we_o    = 1'b1;
        off_wdata_o = off_rdata_i + 1'b1;
        total_d     = total_q + 1'b1;
        state_d     = S_DONE;
      end
      S_FIN_RD: state_d = S_FIN_WR;
      S_FIN_WR: begin
        off_we_o    = 1'b1;
        off_wdata_o = sum_q;
        sum_d = (off_rdata_i > MAXV - sum_q) ? MAXV : sum_q + off_rdata_i;
        r_d   = r_q + 1'b1;
        state_d = (r_q + 1'b1 == rows_i) ? S_FIN_END : S_FIN_RD;
      end
      S_FIN_END: begin
        off_we_o    = 1'b1;
        off_waddr_o = rows_i;
        off_wdata_o = sum_q;
        total_d     = sum_q;
        status_d    = (sum_q == '0) ? ST_MISS : ST_OK;
        state_d     = S_DONE;
      end
      S_RNG_A: state_d = S_RNG_B;
      S_RNG_B: begin
        s_d         = rd_clamp;
        off_raddr_o = r_q + 1'b1;
        state_d     = S_RNG_C;
      end
      S_RNG_C: begin
        // An inverted range is treated as empty.
        e_d  = (s_q > rd_clamp) ? s_q : rd_clamp;
        lo_d = s_q;
        hi_d = (s_q > rd_clamp) ? s_q : rd_clamp;
        i_d  = IW'(s_q) + 1'b1;
        state_d = (op_q == OP_LOOKUP) ? S_LK_RD : S_SRT_NEXT;
      end
      S_LK_RD: begin
        if (lo_q < hi_q) begin
          mid_d       = mid_w;
          col_raddr_o = mid_w[PW-1:0];
          state_d     = S_LK_CMP;
        end else if (lo_q < e_q) begin
          col_raddr_o = lo_q[PW-1:0];
          state_d     = S_LK_FIN;
        end else begin
          status_d = ST_MISS;
          state_d  = S_DONE;
        end
      end
      S_LK_CMP: begin
        if (col_rdata_i < col_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_LK_RD;
      end
      S_LK_FIN: begin
        if (col_rdata_i == col_q) begin
          found_d = 1'b1;
          idx_d   = 10'(lo_q);
        end else begin
          status_d = ST_MISS;
        end
        state_d = S_DONE;
      end
      S_SRT_NEXT: begin
        if (i_q < IW'(e_q)) begin
          state_d = S_SRT_KEY;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = (r_q + 1'b1 == rows_i) ? S_DONE : S_RNG_A;
        end
      end
      S_SRT_KEY: begin
        key_d   = col_rdata_i;
        j_d     = i_q;
        state_d = S_SRT_RD;
      end
      S_SRT_RD: begin
        col_raddr_o = PW'(j_q - 1'b1);
        if (j_q > IW'(s_q)) begin
          state_d = S_SRT_CMP;
        end else begin
          col_we_o = 1'b1;
          i_d      = i_q + 1'b1;
          state_d  = S_SRT_NEXT;
        end
      end
      S_SRT_CMP: begin
        col_we_o = 1'b1;
        if (col_rdata_i > key_q) begin
          col_wdata_o = col_rdata_i;
          j_d         = j_q - 1'b1;
          state_d     = S_SRT_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SRT_NEXT;
        end
      end
      S_DONE: begin
        clr_op_d = 1'b0;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MAXV)
    else $error("element total exceeds store size");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (status_q == ST_OK && op_q == OP_LOOKUP))
    else $error("found flagged with bad status or operation");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LK_RD || state_q == S_LK_CMP) |-> (lo_q <= hi_q && hi_q <= e_q))
    else $error("search bounds out of order");

  a_sort_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRT_RD || state_q == S_SRT_CMP) |-> (j_q <= i_q && j_q >= IW'(s_q)))
    else $error("insertion index out of row");

endmodule

`default_nettype wire

>>> sim/csr_index_build_and_lookup_top_test.sv
`timescale 1ns / 1ps

module csr_index_build_and_lookup_top_test;
  import cibl_pkg::*;

  localparam int NUM_ROWS = 256;
  localparam int STORE_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 60;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  row;
    logic [15:0] column;
    logic [9:0]  position;
    res_t        want;
  } csr_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [7:0]  row_i = '0;
  logic [15:0] column_i = '0;
  logic [9:0]  position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  index_o;
  logic        found_o;
  logic [10:0] total_nonzeros_o;
  logic [1:0]  status_o;

  csr_index_build_and_lookup_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .index_o          (index_o),
    .found_o          (found_o),
    .total_nonzeros_o (total_nonzeros_o),
    .status_o         (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the index structure.
  int          offsets [NUM_ROWS + 1];
  logic [15:0] col_mem [STORE_DEPTH];
  bit          col_written [STORE_DEPTH];
  int          nz_total;
  logic [8:0]  row_count_reg;

  csr_item_t pending_q[$];
  res_t      result_q[$];
  csr_item_t cur_item;
  int        n_items;
  int        n_results;
  int        n_fail;
  int        n_found;
  int        n_overflow;
  int        op_hits [8];
  int        cycles;
  bit        took;
  int        burst_left;
  int        gap_left;
  int        hold_ask;
  int        hold_seen;
  int        hold_left;
  int        stall_mode;

  function automatic int rows_active();
    int r;
    r = row_count_reg;
    if (r == 0) r = 1;
    if (r > NUM_ROWS) r = NUM_ROWS;
    return r;
  endfunction

  function automatic void row_span(input int r, output int s, output int e);
    s = offsets[r];
    e = offsets[r + 1];
    if (s > STORE_DEPTH) s = STORE_DEPTH;
    if (e > STORE_DEPTH) e = STORE_DEPTH;
    if (s > e) e = s;
  endfunction

  function automatic bit span_written(input int s, input int e);
    for (int i = s; i < e; i++) if (!col_written[i]) return 0;
    return 1;
  endfunction

  // Applies one item to the shadow state and returns the result it must give.
  function automatic res_t csr_predict(input csr_item_t it);
    res_t r;
    int rows, s, e, lo, hi, mid, sum, cnt, j;
    logic [15:0] key;
    r = '0;
    r.status = ST_OK;
    rows = rows_active();
    case (it.op)
      OP_CLEAR: begin
        foreach (offsets[i]) offsets[i] = 0;
        nz_total = 0;
      end
      OP_COUNT: begin
        if (it.row >= rows) r.status = ST_MISS;
        else if (nz_total >= STORE_DEPTH) r.status = ST_OVF;
        else begin
          offsets[it.row]++;
          nz_total++;
        end
      end
      OP_FINALIZE: begin
        sum = 0;
        for (int i = 0; i < rows; i++) begin
          cnt = offsets[i];
          offsets[i] = sum;
          if (cnt > STORE_DEPTH - sum) sum = STORE_DEPTH;
          else sum += cnt;
        end
        offsets[rows] = sum;
        nz_total = sum;
        if (sum == 0) r.status = ST_MISS;
      end
      OP_WRITE: begin
        col_mem[it.position] = it.column;
        col_written[it.position] = 1;
      end
      OP_SORT: begin
        for (int i = 0; i < rows; i++) begin
          row_span(i, s, e);
          for (int k = s + 1; k < e; k++) begin
            key = col_mem[k];
            j = k;
            while (j > s && col_mem[j - 1] > key) begin
              col_mem[j] = col_mem[j - 1];
              j--;
            end
            col_mem[j] = key;
          end
        end
      end
      OP_LOOKUP: begin
        if (it.row >= rows) r.status = ST_MISS;
        else begin
          row_span(it.row, s, e);
          lo = s;
          hi = e;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (col_mem[mid] < it.column) lo = mid + 1;
            else hi = mid;
          end
          if (lo < e && col_mem[lo] == it.column) begin
            r.found = 1'b1;
            r.index = lo[9:0];
          end else begin
            r.status = ST_MISS;
          end
        end
      end
      default: ;
    endcase
    r.total_nonzeros = nz_total[10:0];
    return r;
  endfunction

  // Queues an item unless it would make the block read a slot never written.
  task automatic add_item(input logic [2:0] op, input logic [7:0] row,
                          input logic [15:0] column, input logic [9:0] position);
    csr_item_t it;
    int s, e;
    bit ok;
    ok = 1;
    if (op == OP_SORT) begin
      for (int i = 0; i < rows_active(); i++) begin
        row_span(i, s, e);
        if (!span_written(s, e)) ok = 0;
      end
    end else if (op == OP_LOOKUP && row < rows_active()) begin
      row_span(row, s, e);
      ok = span_written(s, e);
    end
    if (ok) begin
      it.op = op;
      it.row = row;
      it.column = column;
      it.position = position;
      it.want = csr_predict(it);
      if (it.want.found) n_found++;
      if (it.want.status == ST_OVF) n_overflow++;
      op_hits[op]++;
      pending_q.push_back(it);
      n_items++;
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || result_q.size() != 0 || in_valid_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_rows(input logic [8:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    row_count_reg = value;
  endtask

  function automatic logic [15:0] pick_column();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: bursts of items with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || took) begin
      took = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        operation_i <= cur_item.op;
        row_i <= cur_item.row;
        column_i <= cur_item.column;
        position_i <= cur_item.position;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      result_q.push_back(cur_item.want);
      took = 1;
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs.
  always @(negedge clk_i) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = 400;
    end
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_mode == 0) begin
      out_stall_i <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("result with no item pending: index %0d found %0d total %0d status %0d",
               index_o, found_o, total_nonzeros_o, status_o);
        n_fail++;
      end else begin
        exp_res = result_q.pop_front();
        if (index_o !== exp_res.index) begin
          $error("index: expected %0d, got %0d", exp_res.index, index_o);
          n_fail++;
        end
        if (found_o !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, found_o);
          n_fail++;
        end
        if (total_nonzeros_o !== exp_res.total_nonzeros) begin
          $error("total_nonzeros: expected %0d, got %0d",
                 exp_res.total_nonzeros, total_nonzeros_o);
          n_fail++;
        end
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("csr_index_build_and_lookup_top_test failed");
      $finish;
    end
  end

  initial begin
    int rows, nc, total, target, choice;
    logic [7:0] r8;
    foreach (offsets[i]) offsets[i] = 0;
    foreach (col_written[i]) col_written[i] = 0;
    nz_total = 0;
    row_count_reg = 9'd1;
    burst_left = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty finalize, out-of-range rows, spare codes, extremes.
    set_rows(9'd4);
    add_item(OP_FINALIZE, 8'd0, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd0, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd1, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd3, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd3, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd4, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd255, 16'hFFFF, 10'd1023);
    add_item(OP_SPARE_A, 8'd255, 16'hFFFF, 10'd1023);
    add_item(OP_SPARE_B, 8'd0, 16'd0, 10'd0);
    add_item(OP_FINALIZE, 8'd0, 16'd0, 10'd0);
    add_item(OP_WRITE, 8'd0, 16'hFFFF, 10'd0);
    add_item(OP_WRITE, 8'd0, 16'h0000, 10'd1);
    add_item(OP_WRITE, 8'd0, 16'h8000, 10'd2);
    add_item(OP_WRITE, 8'd0, 16'h0001, 10'd3);
    add_item(OP_WRITE, 8'd0, 16'h1234, 10'd1023);
    add_item(OP_SORT, 8'd0, 16'd0, 10'd0);
    add_item(OP_LOOKUP, 8'd0, 16'hFFFF, 10'd0);
    add_item(OP_LOOKUP, 8'd1, 16'h0001, 10'd0);
    add_item(OP_LOOKUP, 8'd2, 16'h0000, 10'd0);
    add_item(OP_LOOKUP, 8'd3, 16'h8000, 10'd0);
    add_item(OP_LOOKUP, 8'd3, 16'h0002, 10'd0);
    add_item(OP_LOOKUP, 8'd200, 16'h0000, 10'd0);
    add_item(OP_CLEAR, 8'd0, 16'd0, 10'd0);

    // Fill the store to the limit so the next count overflows, while the
    // receiver holds off long enough for the block to back up.
    set_rows(9'd0);
    hold_ask++;
    for (int i = 0; i < STORE_DEPTH + 2; i++) add_item(OP_COUNT, 8'd0, 16'd0, 10'd0);
    add_item(OP_FINALIZE, 8'd0, 16'd0, 10'd0);
    add_item(OP_COUNT, 8'd0, 16'd0, 10'd0);
    add_item(OP_CLEAR, 8'd0, 16'd0, 10'd0);

    target = n_items + RANDOM_ITEMS;
    while (n_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        choice = $urandom_range(0, 9);
        if (choice == 0) set_rows(9'd256);
        else if (choice == 1) set_rows(9'd511);
        else if (choice == 2) set_rows(9'd0);
        else if (choice == 3) set_rows(9'($urandom));
        else set_rows(9'($urandom_range(1, 8)));
      end else if ($urandom_range(0, 4) == 0) begin
        drain();
      end
      if ($urandom_range(0, 9) == 0) hold_ask++;
      rows = rows_active();
      add_item(OP_CLEAR, 8'($urandom), 16'($urandom), 10'($urandom));
      nc = $urandom_range(0, 30);
      for (int i = 0; i < nc; i++) begin
        r8 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, rows - 1));
        add_item(OP_COUNT, r8, 16'($urandom), 10'($urandom));
      end
      add_item(OP_FINALIZE, 8'($urandom), 16'($urandom), 10'($urandom));
      total = nz_total;
      for (int p = 0; p < total; p++) add_item(OP_WRITE, 8'($urandom), pick_column(), 10'(p));
      if ($urandom_range(0, 4) != 0) add_item(OP_SORT, 8'($urandom), 16'($urandom), 10'($urandom));
      for (int i = $urandom_range(3, 15); i > 0; i--) begin
        if ($urandom_range(0, 9) == 0) begin
          add_item(3'($urandom), 8'($urandom), 16'($urandom), 10'($urandom));
        end else begin
          r8 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, rows - 1));
          if (total > 0 && $urandom_range(0, 2) != 0)
            add_item(OP_LOOKUP, r8, col_mem[$urandom_range(0, total - 1)], 10'($urandom));
          else
            add_item(OP_LOOKUP, r8, pick_column(), 10'($urandom));
        end
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items and %0d results: %0d clear, %0d count, %0d finalize,",
             n_items, n_results, op_hits[OP_CLEAR], op_hits[OP_COUNT], op_hits[OP_FINALIZE]);
    $display("%0d write, %0d sort, %0d lookup (%0d hits), %0d spare codes, %0d overflows.",
             op_hits[OP_WRITE], op_hits[OP_SORT], op_hits[OP_LOOKUP], n_found,
             op_hits[OP_SPARE_A] + op_hits[OP_SPARE_B], n_overflow);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("csr_index_build_and_lookup_top_test passed");
    end else begin
      $display("csr_index_build_and_lookup_top_test failed");
    end
    $finish;
  end

endmodule
